### rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked assertion helpers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define ASSERT_CLK(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_CLK(lbl, prop)
`define ASSERT_NEVER(lbl, expr)
`endif
`endif

### rtl/gtl_pkg.sv
// ----------------------------------------------------------------------------
// Gardner timing loop package
// Shared widths, constants, register indexes and types.
// ----------------------------------------------------------------------------
package gtl_pkg;

  localparam int SAMPLE_BITS_DEF = 16;
  localparam int HISTORY_LEN     = 3;
  localparam int QUEUE_DEPTH     = 2;

  localparam int SYM_W      = 16;
  localparam int SPS_W      = 24;
  localparam int GAIN_W     = 32;
  localparam int ERR_W      = 32;
  localparam int INTEG_W    = 18;
  localparam int FILL_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] REG_SPS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INTEG = 2'd2;

  localparam logic [SPS_W-1:0]  SPS_RESET   = 24'd262144;
  localparam logic [GAIN_W-1:0] PROP_RESET  = 32'd2058874;
  localparam logic [GAIN_W-1:0] INTEG_RESET = 32'd25872564;

  localparam logic signed [ERR_W-1:0] ERR_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [ERR_W-1:0] ERR_MIN = 32'sh8000_0000;

  localparam int INTEG_LIM = 65536;

  // scaled error operand, clipped to 2^48, multiplied in two slices
  localparam int SCL_W    = 49;
  localparam int SCL_LO_W = 25;
  localparam int SCL_HI_W = SCL_W - SCL_LO_W;
  localparam int ACC_W    = SCL_W + SPS_W;
  localparam logic [SCL_W-1:0] SCL_CLIP = {1'b1, 48'b0};

  localparam int LP_SUM_W = 36;
  localparam int PROD_W   = 2 * GAIN_W;
  localparam int CORR_W   = 51;
  localparam int CMAG_W   = CORR_W - 1;

  // divide by ten: q = (n * ceil(2^39 / 10)) >> 39, exact for n < 2^35
  localparam int LP_RCP_W  = LP_SUM_W;
  localparam int LP_RCP_SH = 39;
  localparam int RCP_HALF  = LP_RCP_W / 2;
  localparam int RCP_W     = 2 * LP_RCP_W;
  localparam logic [LP_RCP_W-1:0] LP_RCP = 36'd54975581389;

  typedef struct packed {
    logic [SPS_W-1:0]  sps;
    logic [GAIN_W-1:0] prop_gain;
    logic [GAIN_W-1:0] integ_gain;
  } gtl_cfg_t;

endpackage

### rtl/gtl_sym_if.sv
// ----------------------------------------------------------------------------
// Symbol channel
// One complex symbol word per handshake.
// ----------------------------------------------------------------------------
interface gtl_sym_if;
  import gtl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [SYM_W-1:0] sym_i;
  logic signed [SYM_W-1:0] sym_q;
  modport source (output valid, sym_i, sym_q, input ready);
  modport sink (input valid, sym_i, sym_q, output ready);
endinterface

### rtl/gtl_res_if.sv
// ----------------------------------------------------------------------------
// Result channel
// One timing decision word per handshake.
// ----------------------------------------------------------------------------
interface gtl_res_if;
  import gtl_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    sample_now;
  logic                    loop_ready;
  logic signed [ERR_W-1:0] filtered_error;
  logic [SPS_W-1:0]        offset_now;
  modport source (output valid, sample_now, loop_ready, filtered_error, offset_now,
                  input ready);
  modport sink (input valid, sample_now, loop_ready, filtered_error, offset_now,
                output ready);
endinterface

### rtl/gtl_cfg_if.sv
// ----------------------------------------------------------------------------
// Configuration channel
// Register write words: index and data.
// ----------------------------------------------------------------------------
interface gtl_cfg_if;
  import gtl_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  addr;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, addr, data, input ready);
  modport sink (input valid, addr, data, output ready);
endinterface

### rtl/gtl_queue.sv
// ----------------------------------------------------------------------------
// Word queue
// Small register FIFO between front and back.
// ----------------------------------------------------------------------------
module gtl_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = gtl_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push_valid,
  input  logic [WIDTH-1:0]           push_data,
  output logic                       push_ready,
  output logic                       pop_valid,
  output logic [WIDTH-1:0]           pop_data,
  input  logic                       pop_ready,
  output logic [$clog2(DEPTH+1)-1:0] count
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != CW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end
endmodule

### rtl/gtl_front.sv
// ----------------------------------------------------------------------------
// Gardner loop front end
// Accepts symbols, keeps the history and tags each word as fill or update.
// ----------------------------------------------------------------------------
module gtl_front #(
  parameter int SAMPLE_BITS = gtl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  gtl_sym_if.sink                sym,
  output logic                   push_valid,
  output logic [6*SAMPLE_BITS:0] push_item,
  input  logic                   push_ready
);
  import gtl_pkg::*;

  localparam int SB = SAMPLE_BITS;

  logic signed [SB-1:0] new_i;
  logic signed [SB-1:0] new_q;
  logic signed [SB-1:0] e_i;
  logic signed [SB-1:0] e_q;
  logic signed [SB-1:0] p_i;
  logic signed [SB-1:0] p_q;
  logic [FILL_W-1:0]    fill;
  logic                 filling;
  logic                 accept;

  assign new_i      = SB'($unsigned(sym.sym_i));
  assign new_q      = SB'($unsigned(sym.sym_q));
  assign filling    = (fill < FILL_W'(HISTORY_LEN - 1));
  assign sym.ready  = push_ready;
  assign push_valid = sym.valid;
  assign accept     = sym.valid && push_ready;
  // word layout: fill flag, early, prompt, late
  assign push_item  = {filling, e_i, e_q, p_i, p_q, new_i, new_q};

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (accept && filling) begin
      fill <= fill + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      if (filling) begin
        if (fill == '0) begin
          e_i <= new_i;
          e_q <= new_q;
        end else begin
          p_i <= new_i;
          p_q <= new_q;
        end
      end else begin
        e_i <= p_i;
        e_q <= p_q;
        p_i <= new_i;
        p_q <= new_q;
      end
    end
  end
endmodule

### rtl/gtl_div.sv
// ----------------------------------------------------------------------------
// Gardner loop divider
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module gtl_div #(
  parameter int DW = 50,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [VW-1:0] rem
);
  localparam int CW = $clog2(DW + 1);

  logic [VW-1:0] dvsr;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   trial;
  logic          fits;

  assign trial = {rem, quot[DW-1]};
  assign fits  = (trial >= {1'b0, dvsr});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DW);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvsr <= divisor;
    end else if (busy) begin
      quot <= {quot[DW-2:0], fits};
      rem  <= fits ? VW'(trial - {1'b0, dvsr}) : trial[VW-1:0];
    end
  end
endmodule

### rtl/gtl_back.sv
// ----------------------------------------------------------------------------
// Gardner loop back end
// Error detector, low-pass, PI loop and offset wrap, one word at a time.
// ----------------------------------------------------------------------------
module gtl_back #(
  parameter int SAMPLE_BITS = gtl_pkg::SAMPLE_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  gtl_pkg::gtl_cfg_t      regs,
  input  logic                   item_valid,
  input  logic [6*SAMPLE_BITS:0] item,
  output logic                   item_ready,
  gtl_res_if.source              res
);
  import gtl_pkg::*;

  localparam int SB      = SAMPLE_BITS;
  localparam int TWO_F   = 2 * (SB - 2);
  localparam int MW      = 2 * SB;
  localparam int PRW     = 2 * SB + 1;
  localparam int NW      = 2 * SB + 2;
  localparam int DW      = (2 * SB + 16 > CMAG_W) ? 2 * SB + 16 : CMAG_W;
  localparam int VW      = (MW > SPS_W) ? MW : SPS_W;
  localparam longint FLOOR_PW = (64'd1 << TWO_F) / 64'd1000000;

  typedef enum logic [16:0] {
    ST_IDLE      = 17'h00001,
    ST_MUL       = 17'h00002,
    ST_SUM       = 17'h00004,
    ST_PICK      = 17'h00008,
    ST_DIV_RATIO = 17'h00010,
    ST_SCALE_LO  = 17'h00020,
    ST_SCALE_HI  = 17'h00040,
    ST_ERR       = 17'h00080,
    ST_LP        = 17'h00100,
    ST_LP_LO     = 17'h00200,
    ST_LP_HI     = 17'h00400,
    ST_LP_Q      = 17'h00800,
    ST_GAIN      = 17'h01000,
    ST_INTEG     = 17'h02000,
    ST_CORR      = 17'h04000,
    ST_DIV_MOD   = 17'h08000,
    ST_OUT       = 17'h10000
  } state_t;

  state_t state;

  logic                         fill;
  logic signed [SB-1:0]         e_i, e_q, p_i, p_q, l_i, l_q;
  logic signed [SB:0]           di, dq;
  logic signed [PRW-1:0]        prod_i, prod_q, pw_i, pw_q;
  logic signed [NW-1:0]         num;
  logic [MW-1:0]                m;
  logic [MW-1:0]                pw;
  logic                         neg;
  logic                         ratio_path;
  logic [SCL_W-1:0]             xval;
  logic                         shift16;
  logic [SCL_LO_W+SPS_W-1:0]    mul_lo;
  logic [SCL_HI_W+SPS_W-1:0]    mul_hi;
  logic [ACC_W-1:0]             acc;
  logic [ACC_W-1:0]             rsh;
  logic signed [ERR_W-1:0]      r31;
  logic signed [ERR_W-1:0]      err;
  logic signed [LP_SUM_W-1:0]   lp_sum;
  logic [LP_SUM_W-1:0]          lp_mag;
  logic                         lp_neg;
  logic [LP_SUM_W-1:0]          lp_n;
  logic [2*RCP_HALF-1:0]        rp_ll, rp_lh, rp_hl, rp_hh;
  logic [RCP_W-1:0]             rcp;
  logic [ERR_W-1:0]             lp_q;
  logic [ERR_W-1:0]             lp_abs;
  logic [PROD_W-1:0]            pp, ip, pp_next, ip_next;
  logic                         gneg;
  logic signed [CORR_W-1:0]     ip_s, pp_s, isum, x;
  logic [CMAG_W-1:0]            xmag;
  logic                         xneg;
  logic [SPS_W-1:0]             rem24;
  logic [SPS_W+1:0]             q4, s1, s3;

  logic signed [ERR_W-1:0]      lp;
  logic signed [INTEG_W-1:0]    integ;
  logic [SPS_W-1:0]             offset;

  logic                         div_start, div_done;
  logic [DW-1:0]                div_dividend, div_quot;
  logic [VW-1:0]                div_divisor, div_rem;

  logic                         res_valid;
  logic                         load;

  gtl_div #(.DW(DW), .VW(VW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign item_ready = (state == ST_IDLE);
  assign res.valid  = res_valid;
  assign load       = !res_valid || res.ready;

  assign di         = (SB+1)'(e_i) - (SB+1)'(l_i);
  assign dq         = (SB+1)'(e_q) - (SB+1)'(l_q);
  assign num        = NW'(prod_i) + NW'(prod_q);
  assign ratio_path = (pw > MW'(FLOOR_PW));
  assign mul_lo     = xval[SCL_LO_W-1:0] * regs.sps;
  assign mul_hi     = xval[SCL_W-1:SCL_LO_W] * regs.sps;
  assign rsh        = shift16 ? (acc >> 16) : (acc >> TWO_F);
  assign r31        = {1'b0, rsh[ERR_W-2:0]};
  assign lp_sum     = (LP_SUM_W'(lp) <<< 3) + LP_SUM_W'(lp) + LP_SUM_W'(err);
  assign lp_mag     = (lp_sum < 0) ? LP_SUM_W'(-lp_sum) : LP_SUM_W'(lp_sum);
  assign rp_ll      = lp_n[RCP_HALF-1:0] * LP_RCP[RCP_HALF-1:0];
  assign rp_lh      = lp_n[RCP_HALF-1:0] * LP_RCP[LP_RCP_W-1:RCP_HALF];
  assign rp_hl      = lp_n[LP_RCP_W-1:RCP_HALF] * LP_RCP[RCP_HALF-1:0];
  assign rp_hh      = lp_n[LP_RCP_W-1:RCP_HALF] * LP_RCP[LP_RCP_W-1:RCP_HALF];
  assign lp_q       = rcp[LP_RCP_SH +: ERR_W];
  assign lp_abs     = (lp < 0) ? ERR_W'(-lp) : ERR_W'(lp);
  assign pp_next    = regs.prop_gain * lp_abs;
  assign ip_next    = regs.integ_gain * lp_abs;
  assign ip_s       = gneg ? -CORR_W'(ip[PROD_W-1:16]) : CORR_W'(ip[PROD_W-1:16]);
  assign pp_s       = gneg ? -CORR_W'(pp[PROD_W-1:16]) : CORR_W'(pp[PROD_W-1:16]);
  assign isum       = CORR_W'(integ) + ip_s;
  assign x          = CORR_W'(offset) + pp_s + CORR_W'(integ);
  assign xmag       = (x < 0) ? CMAG_W'(-x) : CMAG_W'(x);
  assign rem24      = div_rem[SPS_W-1:0];
  assign q4         = {offset, 2'b00};
  assign s1         = (SPS_W+2)'(regs.sps);
  assign s3         = s1 + (s1 << 1);

  always_comb begin
    div_start    = 1'b0;
    div_dividend = '0;
    div_divisor  = '0;
    case (state)
      ST_PICK: begin
        div_start    = (regs.sps != '0) && ratio_path;
        div_dividend = DW'({m, 16'b0});
        div_divisor  = VW'(pw);
      end
      ST_CORR: begin
        div_start    = (regs.sps != '0);
        div_dividend = DW'(xmag);
        div_divisor  = VW'(regs.sps);
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      lp        <= '0;
      integ     <= '0;
      offset    <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_valid && res.ready && state != ST_OUT) begin
        res_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (item_valid) begin
            state <= item[6*SB] ? ST_OUT : ST_MUL;
          end
        end
        ST_MUL:       state <= ST_SUM;
        ST_SUM:       state <= ST_PICK;
        ST_PICK: begin
          if (regs.sps == '0) begin
            state <= ST_LP;
          end else if (ratio_path) begin
            state <= ST_DIV_RATIO;
          end else begin
            state <= ST_SCALE_LO;
          end
        end
        ST_DIV_RATIO: if (div_done) state <= ST_SCALE_LO;
        ST_SCALE_LO:  state <= ST_SCALE_HI;
        ST_SCALE_HI:  state <= ST_ERR;
        ST_ERR:       state <= ST_LP;
        ST_LP:        state <= ST_LP_LO;
        ST_LP_LO:     state <= ST_LP_HI;
        ST_LP_HI:     state <= ST_LP_Q;
        ST_LP_Q: begin
          lp    <= lp_neg ? -lp_q : lp_q;
          state <= ST_GAIN;
        end
        ST_GAIN:      state <= ST_INTEG;
        ST_INTEG: begin
          if (isum > CORR_W'(INTEG_LIM)) begin
            integ <= INTEG_W'(INTEG_LIM);
          end else if (isum < -CORR_W'(INTEG_LIM)) begin
            integ <= -INTEG_W'(INTEG_LIM);
          end else begin
            integ <= INTEG_W'(isum);
          end
          state <= ST_CORR;
        end
        ST_CORR: begin
          if (regs.sps == '0) begin
            offset <= '0;
            state  <= ST_OUT;
          end else begin
            state <= ST_DIV_MOD;
          end
        end
        ST_DIV_MOD: begin
          if (div_done) begin
            offset <= (xneg && rem24 != '0) ? regs.sps - rem24 : rem24;
            state  <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (load) begin
            res_valid <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && item_valid) begin
      fill <= item[6*SB];
      e_i  <= $signed(item[5*SB +: SB]);
      e_q  <= $signed(item[4*SB +: SB]);
      p_i  <= $signed(item[3*SB +: SB]);
      p_q  <= $signed(item[2*SB +: SB]);
      l_i  <= $signed(item[SB +: SB]);
      l_q  <= $signed(item[0 +: SB]);
    end
    if (state == ST_MUL) begin
      prod_i <= PRW'(di) * PRW'(p_i);
      prod_q <= PRW'(dq) * PRW'(p_q);
      pw_i   <= PRW'(p_i) * PRW'(p_i);
      pw_q   <= PRW'(p_q) * PRW'(p_q);
    end
    if (state == ST_SUM) begin
      neg <= (num < 0);
      m   <= (num < 0) ? MW'(-num) : MW'(num);
      pw  <= MW'($unsigned(pw_i)) + MW'($unsigned(pw_q));
    end
    if (state == ST_PICK) begin
      if (regs.sps == '0) begin
        err <= '0;
      end
      xval    <= SCL_W'(m);
      shift16 <= 1'b0;
    end
    if (state == ST_DIV_RATIO && div_done) begin
      xval    <= (div_quot > DW'(SCL_CLIP)) ? SCL_CLIP : SCL_W'(div_quot);
      shift16 <= 1'b1;
    end
    if (state == ST_SCALE_LO) begin
      acc <= ACC_W'(mul_lo);
    end
    if (state == ST_SCALE_HI) begin
      acc <= acc + (ACC_W'(mul_hi) << SCL_LO_W);
    end
    if (state == ST_ERR) begin
      if (|rsh[ACC_W-1:ERR_W-1]) begin
        err <= neg ? ERR_MIN : ERR_MAX;
      end else begin
        err <= neg ? -r31 : r31;
      end
    end
    if (state == ST_LP) begin
      lp_neg <= (lp_sum < 0);
      lp_n   <= lp_mag;
    end
    if (state == ST_LP_LO) begin
      rcp <= RCP_W'(rp_ll) + (RCP_W'(rp_lh) << RCP_HALF);
    end
    if (state == ST_LP_HI) begin
      rcp <= rcp + (RCP_W'(rp_hl) << RCP_HALF) + (RCP_W'(rp_hh) << (2 * RCP_HALF));
    end
    if (state == ST_GAIN) begin
      pp   <= pp_next;
      ip   <= ip_next;
      gneg <= (lp < 0);
    end
    if (state == ST_CORR) begin
      xneg <= (x < 0);
    end
    if (state == ST_OUT && load) begin
      res.sample_now     <= !fill && ((q4 < s1) || (q4 > s3));
      res.loop_ready     <= !fill;
      res.filtered_error <= lp;
      res.offset_now     <= offset;
    end
  end
endmodule

### rtl/gardner_timing_loop_core.sv
// ----------------------------------------------------------------------------
// Gardner timing loop core
// Gardner timing error detector with low-pass and PI loop on a sample offset.
// ----------------------------------------------------------------------------
// Each symbol word gives one result word, in order. The first two words after
// reset only fill the history and go from idle straight to the output state
// in the back end. Every later word runs through multiply, add and reciprocal
// divide-by-ten steps and up to two passes of a shared radix-2 divider (error
// normalization, offset wrap modulo samples per symbol) with dividend width
// DW = max(2*SAMPLE_BITS+16, 50). The power floor skips the normalization
// divide, and zero samples per symbol skips both divides. A result that waits
// on the output holds the back end in its output state. A two-word queue lets
// the input side run ahead of the loop and a result register holds a finished
// word while the next one starts.
// Configuration is written through a single always-ready port.
`include "assert_macros.svh"

module gardner_timing_loop_core #(
  parameter int SAMPLE_BITS = gtl_pkg::SAMPLE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst,
  gtl_cfg_if.sink   cfg,
  gtl_sym_if.sink   sym,
  gtl_res_if.source res
);
  import gtl_pkg::*;

  localparam int IW  = 6 * SAMPLE_BITS + 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);

  gtl_cfg_t       cfg_regs;
  logic           push_valid, push_ready;
  logic           pop_valid, pop_ready;
  logic [IW-1:0]  push_item, pop_item;
  logic [QCW-1:0] q_count;
  logic           live_word;

  assign cfg.ready = 1'b1;
  assign live_word = res.valid && res.loop_ready && (cfg_regs.sps != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.sps        <= SPS_RESET;
      cfg_regs.prop_gain  <= PROP_RESET;
      cfg_regs.integ_gain <= INTEG_RESET;
    end else if (cfg.valid) begin
      case (cfg.addr)
        REG_SPS:   cfg_regs.sps        <= cfg.data[SPS_W-1:0];
        REG_PROP:  cfg_regs.prop_gain  <= cfg.data;
        REG_INTEG: cfg_regs.integ_gain <= cfg.data;
        default:   cfg_regs.sps        <= cfg_regs.sps;
      endcase
    end
  end

  gtl_front #(.SAMPLE_BITS(SAMPLE_BITS)) u_front (
    .clk        (clk),
    .rst        (rst),
    .sym        (sym),
    .push_valid (push_valid),
    .push_item  (push_item),
    .push_ready (push_ready)
  );

  gtl_queue #(.WIDTH(IW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_data  (push_item),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_item),
    .pop_ready  (pop_ready),
    .count      (q_count)
  );

  gtl_back #(.SAMPLE_BITS(SAMPLE_BITS)) u_back (
    .clk        (clk),
    .rst        (rst),
    .regs       (cfg_regs),
    .item_valid (pop_valid),
    .item       (pop_item),
    .item_ready (pop_ready),
    .res        (res)
  );

  `ASSERT_NEVER(a_queue_overflow, q_count > QCW'(QUEUE_DEPTH))
  `ASSERT_CLK(a_no_sample_while_filling, res.valid && !res.loop_ready |-> !res.sample_now)
  `ASSERT_CLK(a_offset_in_range, live_word |-> res.offset_now < cfg_regs.sps)
endmodule
